[design/probe_reply_gate_unit_assert.svh]
// Assertion macros shared by the checker of the probe reply gate.
`ifndef PROBE_REPLY_GATE_UNIT_ASSERT_SVH
`define PROBE_REPLY_GATE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define PRG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, idle during reset.
`define PRG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/prg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prg_pkg;

   // Default number of remembered sources.
   localparam int SLOTS_DEFAULT = 16;

   // Register reset values.
   localparam logic [31:0] REPLY_GAP_RESET = 32'd1000;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GAME_ID      = 3'd0;
   localparam logic [2:0] CSR_IFACE_ENABLE = 3'd1;
   localparam logic [2:0] CSR_IFACE0_ADDR  = 3'd2;
   localparam logic [2:0] CSR_IFACE0_MASK  = 3'd3;
   localparam logic [2:0] CSR_IFACE1_ADDR  = 3'd4;
   localparam logic [2:0] CSR_IFACE1_MASK  = 3'd5;
   localparam logic [2:0] CSR_REPLY_GAP    = 3'd6;

   // Verdict codes carried on the result channel.
   typedef enum logic [1:0] {
      VERDICT_REPLY   = 2'd0,
      VERDICT_GAME    = 2'd1,
      VERDICT_REMOTE  = 2'd2,
      VERDICT_LIMITED = 2'd3
   } prg_verdict_type;

   // One remembered source: address, time of the last reply and a valid flag.
   typedef struct packed {
      logic [31:0] src;
      logic [31:0] stamp;
      logic        valid;
   } prg_entry_type;

endpackage

`default_nettype wire

[design/prg_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Probe channel: one item per discovery probe.
interface prg_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_addr;
   logic [31:0] probe_game;
   logic [31:0] now_ms;

   modport source (output valid, output src_addr, output probe_game, output now_ms,
                   input ready);
   modport sink (input valid, input src_addr, input probe_game, input now_ms,
                 output ready);
endinterface

`default_nettype wire

[design/prg_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Decision channel: one item per probe.
interface prg_rsp_if;
   logic       valid;
   logic       ready;
   logic       reply;
   logic [1:0] verdict;

   modport source (output valid, output reply, output verdict, input ready);
   modport sink (input valid, input reply, input verdict, output ready);
endinterface

`default_nettype wire

[design/prg_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One table cell. During a scan it takes the entry of its downstream
// neighbor; a direct write loads a new source into it.
module prg_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift_en,
   input  wire prg_pkg::prg_entry_type shift_in,
   input  wire logic                   write_en,
   input  wire prg_pkg::prg_entry_type write_in,
   output prg_pkg::prg_entry_type      entry
);

   logic        valid_ff;
   logic [31:0] src_ff;
   logic [31:0] stamp_ff;

   // The valid flag is control state and clears on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (write_en) begin
         valid_ff <= write_in.valid;
      end else if (shift_en) begin
         valid_ff <= shift_in.valid;
      end
   end

   // Address and time are payload and only move with the flag.
   always_ff @(posedge clock) begin
      if (write_en) begin
         src_ff   <= write_in.src;
         stamp_ff <= write_in.stamp;
      end else if (shift_en) begin
         src_ff   <= shift_in.src;
         stamp_ff <= shift_in.stamp;
      end
   end

   assign entry.src   = src_ff;
   assign entry.stamp = stamp_ff;
   assign entry.valid = valid_ff;

endmodule

`default_nettype wire

[design/probe_reply_gate_unit.sv]
// Probe reply gate: takes one discovery probe (source address, game id, time
// in ms) and returns one decision: other game, source not on an enabled local
// subnet, rate limited, or reply. The game and subnet checks finish in the
// cycle the probe is taken, so a filtered probe goes straight to ST_DONE and
// then to the output register once it is free. A probe that passes them
// rotates the source table once through its ring of SLOTS cells, one cell per
// cycle, with the address compare and the wrapping time check at the head
// cell; then ST_FILL refills the entry at the replacement pointer for a new
// source. The next probe is taken in the cycle after the result is loaded
// into the output register. The table needs no clearing after reset. The
// user writes configuration through csr_* only while no probe is in flight;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module probe_reply_gate_unit #(
   parameter int SLOTS = prg_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   prg_req_if.sink          req_chan,
   prg_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [31:0] game_id_ff;
   logic [1:0]  iface_enable_ff;
   logic [31:0] iface0_addr_ff;
   logic [31:0] iface0_mask_ff;
   logic [31:0] iface1_addr_ff;
   logic [31:0] iface1_mask_ff;
   logic [31:0] reply_gap_ff;

   // Control and result registers.
   state_type                state_ff;
   logic [PTR_W-1:0]         step_ff;
   logic [PTR_W-1:0]         ptr_ff;
   logic                     found_ff;
   prg_pkg::prg_verdict_type verdict_ff;
   logic [31:0]              src_ff;
   logic [31:0]              now_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_reply_ff;
   prg_pkg::prg_verdict_type rsp_verdict_ff;

   // Table ring.
   prg_pkg::prg_entry_type cell_q  [SLOTS];
   prg_pkg::prg_entry_type shift_d [SLOTS];
   prg_pkg::prg_entry_type head_mod;
   prg_pkg::prg_entry_type new_entry;
   logic [SLOTS-1:0]       write_en;

   logic        req_take;
   logic        game_ok;
   logic        local_ok;
   logic        head_hit;
   logic        gap_ok;
   logic [31:0] age;
   logic        last_step;
   logic        out_free;

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         game_id_ff      <= '0;
         iface_enable_ff <= '0;
         iface0_addr_ff  <= '0;
         iface0_mask_ff  <= '0;
         iface1_addr_ff  <= '0;
         iface1_mask_ff  <= '0;
         reply_gap_ff    <= prg_pkg::REPLY_GAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            prg_pkg::CSR_GAME_ID:      game_id_ff      <= csr_wdata;
            prg_pkg::CSR_IFACE_ENABLE: iface_enable_ff <= csr_wdata[1:0];
            prg_pkg::CSR_IFACE0_ADDR:  iface0_addr_ff  <= csr_wdata;
            prg_pkg::CSR_IFACE0_MASK:  iface0_mask_ff  <= csr_wdata;
            prg_pkg::CSR_IFACE1_ADDR:  iface1_addr_ff  <= csr_wdata;
            prg_pkg::CSR_IFACE1_MASK:  iface1_mask_ff  <= csr_wdata;
            prg_pkg::CSR_REPLY_GAP:    reply_gap_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Game and subnet checks on the incoming probe.
   assign req_take = req_chan.valid && (state_ff == ST_IDLE);
   assign game_ok  = (req_chan.probe_game == game_id_ff);
   assign local_ok =
      (iface_enable_ff[0] && (((iface0_addr_ff ^ req_chan.src_addr) & iface0_mask_ff) == '0)) ||
      (iface_enable_ff[1] && (((iface1_addr_ff ^ req_chan.src_addr) & iface1_mask_ff) == '0));

   // Head cell compare: first valid entry with this source decides the gap.
   assign head_hit  = (state_ff == ST_SCAN) && !found_ff && cell_q[0].valid &&
                      (cell_q[0].src == src_ff);
   assign age       = now_ff - cell_q[0].stamp;
   assign gap_ok    = (age >= reply_gap_ff);
   assign last_step = (step_ff == PTR_W'(SLOTS - 1));

   // The head entry re-enters at the tail, with a fresh time when answered.
   always_comb begin
      head_mod = cell_q[0];
      if (head_hit && gap_ok) begin
         head_mod.stamp = now_ff;
      end
   end

   assign new_entry.src   = src_ff;
   assign new_entry.stamp = now_ff;
   assign new_entry.valid = 1'b1;

   // Ring of cells; after SLOTS shifts every entry is back in its own cell.
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      if (k == SLOTS - 1) begin : g_tail
         assign shift_d[k] = head_mod;
      end else begin : g_body
         assign shift_d[k] = cell_q[k+1];
      end

      assign write_en[k] = (state_ff == ST_FILL) && !found_ff && (ptr_ff == PTR_W'(k));

      prg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (state_ff == ST_SCAN),
         .shift_in (shift_d[k]),
         .write_en (write_en[k]),
         .write_in (new_entry),
         .entry    (cell_q[k])
      );
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         ptr_ff         <= '0;
         found_ff       <= 1'b0;
         verdict_ff     <= prg_pkg::VERDICT_REPLY;
         src_ff         <= '0;
         now_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_reply_ff   <= 1'b0;
         rsp_verdict_ff <= prg_pkg::VERDICT_REPLY;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  src_ff   <= req_chan.src_addr;
                  now_ff   <= req_chan.now_ms;
                  found_ff <= 1'b0;
                  step_ff  <= '0;
                  if (!game_ok) begin
                     verdict_ff <= prg_pkg::VERDICT_GAME;
                     state_ff   <= ST_DONE;
                  end else if (!local_ok) begin
                     verdict_ff <= prg_pkg::VERDICT_REMOTE;
                     state_ff   <= ST_DONE;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (head_hit) begin
                  found_ff   <= 1'b1;
                  verdict_ff <= gap_ok ? prg_pkg::VERDICT_REPLY : prg_pkg::VERDICT_LIMITED;
               end
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  state_ff <= ST_FILL;
               end
            end
            ST_FILL: begin
               // A new source takes the entry at the pointer, which then moves on.
               if (!found_ff) begin
                  verdict_ff <= prg_pkg::VERDICT_REPLY;
                  ptr_ff     <= (ptr_ff == PTR_W'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_reply_ff   <= (verdict_ff == prg_pkg::VERDICT_REPLY);
                  rsp_verdict_ff <= verdict_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.reply   = rsp_reply_ff;
   assign rsp_chan.verdict = rsp_verdict_ff;

endmodule

`default_nettype wire

[design/prg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "probe_reply_gate_unit_assert.svh"

// Port-level checks of the probe reply gate.
module prg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_reply,
   input wire logic [1:0] rsp_verdict
);

   // The reply flag agrees with the verdict code.
   `PRG_ASSERT_NOW(a_reply_matches_verdict, rsp_valid, rsp_reply == (rsp_verdict == prg_pkg::VERDICT_REPLY), "reply flag disagrees with verdict")

   // Only one probe is in flight: taking one closes the input in the next cycle.
   `PRG_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "input stayed open after a probe was taken")

   // A probe taken now has no result in the very next cycle beyond what was held.
   `PRG_ASSERT_NEXT(a_no_early_result, req_valid && req_ready && !rsp_valid, !rsp_valid, "result appeared before the probe was checked")

   // A stalled result holds its value.
   `PRG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict) && $stable(rsp_reply), "stalled result changed")

endmodule

bind probe_reply_gate_unit prg_checker u_prg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_reply   (rsp_chan.reply),
   .rsp_verdict (rsp_chan.verdict)
);

`default_nettype wire

[tb/tb_probe_reply_gate_unit.sv]
`timescale 1ns / 1ps

module tb_probe_reply_gate_unit;
   import prg_pkg::*;

   localparam int SLOT_COUNT    = SLOTS_DEFAULT;
   localparam int PHASES        = 14;
   localparam int PHASE_ITEMS   = 100;
   localparam int POOL_SIZE     = 24;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_AFTER    = 300;
   localparam int HOLD_CYCLES   = 250;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 40;
   localparam int PLAN_ROWS     = 27;

   // Index that decodes to no register; writes to it must be dropped.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   // One decision as it is expected on the result channel.
   typedef struct packed {
      logic            reply;
      prg_verdict_type verdict;
   } decision_t;

   // One row of the directed plan: a register write or a probe.
   typedef struct packed {
      logic            is_reg;
      logic [2:0]      reg_index;
      logic [31:0]     reg_data;
      logic [31:0]     src;
      logic [31:0]     game;
      logic [31:0]     now;
      logic            typed;
      prg_verdict_type verdict;
   } plan_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   prg_req_if req_chan ();
   prg_rsp_if rsp_chan ();

   probe_reply_gate_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the registers.
   logic [31:0] cfg_game;
   logic [1:0]  cfg_enable;
   logic [31:0] cfg_addr [2];
   logic [31:0] cfg_mask [2];
   logic [31:0] cfg_gap;

   // Shadow copy of the source table.
   logic [31:0] seen_src [SLOT_COUNT];
   logic [31:0] seen_stamp [SLOT_COUNT];
   logic        seen_valid [SLOT_COUNT];
   int          refill_ptr;

   decision_t   pending_decisions [$];
   plan_row_t   plan_rows [PLAN_ROWS];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          probes_sent = 0;
   int          settings_count = 0;
   int          verdict_seen [4] = '{0, 0, 0, 0};
   logic        sender_burst = 1'b0;

   // Random stimulus shaping for the current phase.
   logic [31:0] source_pool [POOL_SIZE];
   logic [31:0] wall_ms;
   int          step_max;

   // Two-phase clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: ends the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_decisions.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   function automatic logic [31:0] net_mask(input int prefix);
      return (prefix == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - prefix));
   endfunction

   // Applies one register write to the shadow configuration.
   function automatic void apply_reg(input logic [2:0] index, input logic [31:0] data);
      case (index)
         CSR_GAME_ID:      cfg_game = data;
         CSR_IFACE_ENABLE: cfg_enable = data[1:0];
         CSR_IFACE0_ADDR:  cfg_addr[0] = data;
         CSR_IFACE0_MASK:  cfg_mask[0] = data;
         CSR_IFACE1_ADDR:  cfg_addr[1] = data;
         CSR_IFACE1_MASK:  cfg_mask[1] = data;
         CSR_REPLY_GAP:    cfg_gap = data;
         default: ;
      endcase
   endfunction

   // Decides one probe and updates the shadow table the way the block must.
   function automatic decision_t judge_probe(input logic [31:0] src, input logic [31:0] game,
                                             input logic [31:0] now);
      decision_t   d;
      logic        on_net;
      int          hit;
      logic [31:0] age;
      on_net = 1'b0;
      hit = -1;
      d.verdict = VERDICT_REPLY;
      if (game != cfg_game) begin
         d.verdict = VERDICT_GAME;
      end else begin
         for (int k = 0; k < 2; k++)
            if (cfg_enable[k] && (((cfg_addr[k] ^ src) & cfg_mask[k]) == 32'h0))
               on_net = 1'b1;
         if (!on_net) begin
            d.verdict = VERDICT_REMOTE;
         end else begin
            for (int k = 0; k < SLOT_COUNT; k++)
               if (hit < 0 && seen_valid[k] && seen_src[k] == src)
                  hit = k;
            if (hit >= 0) begin
               // Known source: the wrapped age decides.
               age = now - seen_stamp[hit];
               if (age < cfg_gap)
                  d.verdict = VERDICT_LIMITED;
               else
                  seen_stamp[hit] = now;
            end else begin
               // New source takes the entry at the refill pointer.
               seen_src[refill_ptr] = src;
               seen_stamp[refill_ptr] = now;
               seen_valid[refill_ptr] = 1'b1;
               refill_ptr = (refill_ptr == SLOT_COUNT - 1) ? 0 : refill_ptr + 1;
            end
         end
      end
      d.reply = (d.verdict == VERDICT_REPLY);
      return d;
   endfunction

   function automatic plan_row_t probe_row(input logic [31:0] src, input logic [31:0] game,
                                           input logic [31:0] now, input logic typed = 1'b0,
                                           input prg_verdict_type verdict = VERDICT_REPLY);
      plan_row_t r;
      r = '0;
      r.src = src;
      r.game = game;
      r.now = now;
      r.typed = typed;
      r.verdict = verdict;
      return r;
   endfunction

   function automatic plan_row_t reg_row(input logic [2:0] index, input logic [31:0] data);
      plan_row_t r;
      r = '0;
      r.is_reg = 1'b1;
      r.reg_index = index;
      r.reg_data = data;
      return r;
   endfunction

   // Drives one register write; the caller lowers csr_we after the last one.
   task automatic reg_write(input logic [2:0] index, input logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      apply_reg(index, data);
      @(posedge clock);
   endtask

   // Stops offering probes and waits until the block has nothing in flight.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_decisions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      settings_count++;
   endtask

   // Offers one probe after a random gap and records its expected decision.
   task automatic send_probe(input logic [31:0] src, input logic [31:0] game,
                             input logic [31:0] now, input logic typed,
                             input prg_verdict_type verdict);
      int        gap;
      decision_t want;
      if ($urandom_range(0, 39) == 0)
         sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.src_addr <= src;
      req_chan.probe_game <= game;
      req_chan.now_ms <= now;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      want = judge_probe(src, game, now);
      if (typed) begin
         want.verdict = verdict;
         want.reply = (verdict == VERDICT_REPLY);
      end
      pending_decisions.push_back(want);
      probes_sent++;
   endtask

   // Writes every register for one random phase and prepares its source pool.
   task automatic program_phase(input int phase);
      logic [31:0] gap;
      logic [31:0] game;
      logic [1:0]  en;
      int          side;
      en = (phase == 4) ? 2'd0 : 2'($urandom_range(1, 3));
      game = (phase == 2) ? 32'h0 : (phase == 3) ? 32'hFFFF_FFFF : $urandom;
      case (phase % 5)
         0:       gap = 32'h0;
         1:       gap = 32'hFFFF_FFFF;
         2:       gap = 32'd1000;
         default: gap = $urandom_range(1, 5000);
      endcase
      reg_write(CSR_GAME_ID, game);
      reg_write(CSR_IFACE_ENABLE, ($urandom & 32'hFFFF_FFFC) | {30'h0, en});
      reg_write(CSR_IFACE0_ADDR, $urandom);
      reg_write(CSR_IFACE0_MASK, (phase == 1) ? 32'hFFFF_FFFF : net_mask($urandom_range(0, 32)));
      reg_write(CSR_IFACE1_ADDR, $urandom);
      reg_write(CSR_IFACE1_MASK, (phase == 1) ? 32'h0 : net_mask($urandom_range(0, 32)));
      reg_write(CSR_REPLY_GAP, gap);
      if ($urandom_range(0, 1) == 1)
         reg_write(CSR_UNUSED, $urandom);
      csr_we <= 1'b0;

      // Sources on the enabled subnets, more of them than the table holds.
      for (int k = 0; k < POOL_SIZE; k++) begin
         side = (en[1] && (!en[0] || $urandom_range(0, 1) == 1)) ? 1 : 0;
         source_pool[k] = (cfg_addr[side] & cfg_mask[side]) | ($urandom & ~cfg_mask[side]);
      end
      wall_ms = (phase == 3) ? 32'hFFFF_F000 : $urandom;
      if (gap == 32'h0)
         step_max = 50;
      else if (gap == 32'hFFFF_FFFF)
         step_max = 2000;
      else
         step_max = int'(gap) / $urandom_range(4, 24) + 1;
   endtask

   // Result sink: random stalls, bursts without stalls, and one long hold-off.
   initial begin : result_sink
      int   stall;
      int   taken;
      logic calm;
      taken = 0;
      calm = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0)
            calm = !calm;
         stall = (taken == HOLD_AFTER) ? HOLD_CYCLES : (calm ? 0 : $urandom_range(0, 8));
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid)
            @(posedge clock);
         taken++;
      end
   end

   // Compares each accepted result with the oldest expected decision.
   always @(posedge clock) begin : result_check
      decision_t want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_decisions.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: reply %b verdict %0d",
                                      rsp_chan.reply, rsp_chan.verdict));
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_chan.reply !== want.reply)
               report_mismatch($sformatf("reply %b, expected %b",
                                         rsp_chan.reply, want.reply));
            if (rsp_chan.verdict !== want.verdict)
               report_mismatch($sformatf("verdict %0d, expected %s",
                                         rsp_chan.verdict, want.verdict.name()));
         end
         if (!$isunknown(rsp_chan.verdict))
            verdict_seen[rsp_chan.verdict]++;
      end
   end

   // Main sequence: reset, directed plan, then random phases.
   initial begin : stimulus
      logic        writing;
      int          roll;
      logic [31:0] src;
      logic [31:0] game;
      logic [31:0] now;
      writing = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.src_addr <= 32'h0;
      req_chan.probe_game <= 32'h0;
      req_chan.now_ms <= 32'h0;
      csr_we <= 1'b0;
      csr_index <= 3'd0;
      csr_wdata <= 32'h0;

      // Shadow state after reset.
      cfg_game = 32'h0;
      cfg_enable = 2'd0;
      cfg_addr = '{32'h0, 32'h0};
      cfg_mask = '{32'h0, 32'h0};
      cfg_gap = REPLY_GAP_RESET;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         seen_src[k] = 32'h0;
         seen_stamp[k] = 32'h0;
         seen_valid[k] = 1'b0;
      end
      refill_ptr = 0;

      plan_rows = '{
         // Reset values: game 0 and no interface enabled.
         probe_row(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, VERDICT_GAME),
         probe_row(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, VERDICT_REMOTE),
         reg_row(CSR_GAME_ID, 32'hFFFF_FFFF),
         reg_row(CSR_IFACE0_ADDR, 32'hC0A8_0100),
         reg_row(CSR_IFACE0_MASK, 32'hFFFF_FF00),
         reg_row(CSR_IFACE_ENABLE, 32'h0000_0001),
         // Reset gap of 1000 ms: just inside and just at the limit.
         probe_row(32'hC0A8_01FF, 32'hFFFF_FFFF, 32'd0, 1'b1, VERDICT_REPLY),
         probe_row(32'hC0A8_01FF, 32'hFFFF_FFFF, 32'd999, 1'b1, VERDICT_LIMITED),
         probe_row(32'hC0A8_01FF, 32'hFFFF_FFFF, 32'd1000, 1'b1, VERDICT_REPLY),
         probe_row(32'hC0A8_0201, 32'hFFFF_FFFF, 32'd1000, 1'b1, VERDICT_REMOTE),
         probe_row(32'hC0A8_0100, 32'hFFFF_FFFE, 32'd1000, 1'b1, VERDICT_GAME),
         probe_row(32'hC0A8_0100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, VERDICT_REPLY),
         // Time wraps past zero: the age is small again.
         probe_row(32'hC0A8_01FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
         probe_row(32'hC0A8_01FF, 32'hFFFF_FFFF, 32'h0000_0100, 1'b1, VERDICT_LIMITED),
         // Second pair with a zero mask matches everything; zero gap.
         reg_row(CSR_IFACE1_ADDR, 32'h0A00_0000),
         reg_row(CSR_IFACE1_MASK, 32'h0000_0000),
         reg_row(CSR_IFACE_ENABLE, 32'h0000_0002),
         reg_row(CSR_REPLY_GAP, 32'h0000_0000),
         probe_row(32'h0000_0000, 32'hFFFF_FFFF, 32'd5, 1'b1, VERDICT_REPLY),
         probe_row(32'h0000_0000, 32'hFFFF_FFFF, 32'd5, 1'b1, VERDICT_REPLY),
         probe_row(32'hC0A8_01FF, 32'hFFFF_FFFF, 32'h0000_0100),
         // Largest gap; a write to the unused index must not disturb it.
         reg_row(CSR_REPLY_GAP, 32'hFFFF_FFFF),
         reg_row(CSR_UNUSED, 32'h0000_0000),
         probe_row(32'h0000_0000, 32'hFFFF_FFFF, 32'd6, 1'b1, VERDICT_LIMITED),
         reg_row(CSR_IFACE_ENABLE, 32'hFFFF_FFFF),
         probe_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000),
         probe_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, VERDICT_GAME)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan: register rows are written only once the block is idle.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (plan_rows[i].is_reg) begin
            if (!writing) begin
               settle();
               writing = 1'b1;
            end
            reg_write(plan_rows[i].reg_index, plan_rows[i].reg_data);
         end else begin
            if (writing) begin
               csr_we <= 1'b0;
               writing = 1'b0;
            end
            send_probe(plan_rows[i].src, plan_rows[i].game, plan_rows[i].now,
                       plan_rows[i].typed, plan_rows[i].verdict);
         end
      end

      // Random phases: mostly matching game and local sources, some noise.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         program_phase(phase);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               src = $urandom;
               game = $urandom;
               now = $urandom;
            end else begin
               src = (roll < 14) ? $urandom : source_pool[$urandom_range(0, POOL_SIZE - 1)];
               game = (roll < 20) ? (cfg_game ^ (32'h1 << $urandom_range(0, 31))) : cfg_game;
               wall_ms = wall_ms + $urandom_range(0, step_max);
               now = wall_ms;
            end
            send_probe(src, game, now, 1'b0, VERDICT_REPLY);
         end
      end
      settle();

      if (pending_decisions.size() != 0)
         report_mismatch($sformatf("%0d decisions never arrived", pending_decisions.size()));
      $display("Sent %0d probes over %0d register settings, including one long result stall.",
               probes_sent, settings_count);
      $display("Decisions seen: reply %0d, other game %0d, not local %0d, rate limited %0d.",
               verdict_seen[VERDICT_REPLY], verdict_seen[VERDICT_GAME],
               verdict_seen[VERDICT_REMOTE], verdict_seen[VERDICT_LIMITED]);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
